// ----- src/iss_pkg.sv -----
`default_nettype none

package iss_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosFldW = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntFldW = 5;

  typedef enum logic [OpW-1:0] {
    OP_INS_POS  = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_DEL_HEAD = 3'd4,
    OP_DEL_TAIL = 3'd5,
    OP_READ     = 3'd6
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // decoded request, handed from decode to the cell row and result stage
  typedef struct packed {
    logic    ins;
    logic    del;
    logic    rd_ok;
    logic    rd_fail;
    status_e status;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/iss_req_if.sv -----
`default_nettype none

interface iss_req_if;
  logic                                valid;
  logic                                ready;
  logic        [iss_pkg::OpW-1:0]      operation;
  logic        [iss_pkg::PosFldW-1:0]  position;
  logic signed [iss_pkg::DataW-1:0]    value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

`default_nettype wire

// ----- src/iss_rsp_if.sv -----
`default_nettype none

interface iss_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [iss_pkg::StatW-1:0]    status;
  logic signed [iss_pkg::DataW-1:0]    read_value;
  logic        [iss_pkg::CntFldW-1:0]  entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ----- src/indexed_sequence_store.sv -----
// channel | dir | handshake   | payload
// req_i   | in  | valid/ready | operation, position, value
// rsp_o   | out | valid/ready | status, read_value, entry_count
//
// one request per cycle while req_i.ready is high; a beat moves from the request register
// into the result register, which drives rsp_o.valid, and leaves with the reply beat.
// the list update and the result load on the same edge.
// reset clears the entry count and both valid flags; stored values stay undefined.
// a stalled result holds the request register, and req_i.ready drops only while both
// registers are full and rsp_o.ready is low.
`default_nettype none

module indexed_sequence_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iss_req_if.sink    req_i,
  iss_rsp_if.source  rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > iss_pkg::PosFldW) ? CntW : iss_pkg::PosFldW;

  logic                          req_valid_q;
  logic [iss_pkg::OpW-1:0]       op_q;
  logic [iss_pkg::PosFldW-1:0]   pos_q;
  logic [iss_pkg::DataW-1:0]     val_q;

  logic                          res_valid_q;
  iss_pkg::status_e              status_q;
  iss_pkg::status_e              status_d;
  logic [iss_pkg::DataW-1:0]     rdval_q;
  logic [iss_pkg::DataW-1:0]     rdval_d;
  logic [iss_pkg::CntFldW-1:0]   count_q;
  logic [iss_pkg::CntFldW-1:0]   count_d;

  logic                          advance;
  logic                          process;
  logic                          req_take;
  iss_pkg::cmd_t                 cmd;
  logic [PosW-1:0]               eff_pos;
  logic [CntW-1:0]               cnt;
  logic [CntW-1:0]               cnt_next;
  logic [PosW-1:0]               cnt_next_w;
  logic [iss_pkg::DataW-1:0]     rd_data;

  assign advance     = !res_valid_q || rsp_o.ready;
  assign process     = req_valid_q && advance;
  assign req_i.ready = !req_valid_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  iss_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .operation_i (op_q),
    .position_i  (pos_q),
    .cnt_i       (cnt),
    .cmd_o       (cmd),
    .pos_o       (eff_pos)
  );

  iss_cells #(
    .CAPACITY (CAPACITY)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (process),
    .cmd_i      (cmd),
    .pos_i      (eff_pos),
    .value_i    (val_q),
    .cnt_o      (cnt),
    .cnt_next_o (cnt_next),
    .rd_data_o  (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      op_q  <= req_i.operation;
      pos_q <= req_i.position;
      val_q <= req_i.value;
    end
  end

  assign cnt_next_w = PosW'(cnt_next);
  assign count_d    = cnt_next_w[iss_pkg::CntFldW-1:0];
  assign status_d   = cmd.status;

  always_comb begin
    rdval_d = '0;
    if (cmd.rd_ok) begin
      rdval_d = rd_data;
    end else if (cmd.rd_fail) begin
      rdval_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      count_q  <= count_d;
    end
  end

  assign rsp_o.valid       = res_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = rdval_q;
  assign rsp_o.entry_count = count_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !res_valid_q |=> res_valid_q)
    else $error("request lost on its way to the result register");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && status_q == iss_pkg::ST_FULL |-> cnt == CntW'(CAPACITY))
    else $error("full reported while list not full");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && status_q == iss_pkg::ST_EMPTY |-> cnt == '0)
    else $error("empty reported while list holds entries");
`endif

endmodule

`default_nettype wire

// ----- src/iss_decode.sv -----
`default_nettype none

module iss_decode #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic [iss_pkg::OpW-1:0]     operation_i,
  input  wire logic [iss_pkg::PosFldW-1:0] position_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0] cnt_i,
  output iss_pkg::cmd_t                    cmd_o,
  output logic [((($clog2(CAPACITY+1)) > iss_pkg::PosFldW) ?
                 $clog2(CAPACITY+1) : iss_pkg::PosFldW)-1:0] pos_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > iss_pkg::PosFldW) ? CntW : iss_pkg::PosFldW;

  logic [PosW-1:0] pos_w;
  logic [PosW-1:0] cnt_w;
  logic            full;
  logic            empty;

  assign pos_w = PosW'(position_i);
  assign cnt_w = PosW'(cnt_i);
  assign full  = (cnt_i == CntW'(CAPACITY));
  assign empty = (cnt_i == '0);

  always_comb begin
    cmd_o         = '0;
    cmd_o.status  = iss_pkg::ST_BAD_POS;
    pos_o         = '0;
    unique case (iss_pkg::op_e'(operation_i))
      iss_pkg::OP_INS_POS: begin
        pos_o = pos_w;
        if (pos_w > cnt_w) begin
          cmd_o.status = iss_pkg::ST_BAD_POS;
        end else if (full) begin
          cmd_o.status = iss_pkg::ST_FULL;
        end else begin
          cmd_o.status = iss_pkg::ST_OK;
          cmd_o.ins    = 1'b1;
        end
      end
      iss_pkg::OP_INS_HEAD, iss_pkg::OP_INS_TAIL: begin
        pos_o = (iss_pkg::op_e'(operation_i) == iss_pkg::OP_INS_TAIL) ? cnt_w : '0;
        if (full) begin
          cmd_o.status = iss_pkg::ST_FULL;
        end else begin
          cmd_o.status = iss_pkg::ST_OK;
          cmd_o.ins    = 1'b1;
        end
      end
      iss_pkg::OP_DEL_POS: begin
        pos_o = pos_w;
        if (empty) begin
          cmd_o.status = iss_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          cmd_o.status = iss_pkg::ST_BAD_POS;
        end else begin
          cmd_o.status = iss_pkg::ST_OK;
          cmd_o.del    = 1'b1;
        end
      end
      iss_pkg::OP_DEL_HEAD, iss_pkg::OP_DEL_TAIL: begin
        pos_o = (iss_pkg::op_e'(operation_i) == iss_pkg::OP_DEL_TAIL) ?
                (cnt_w - PosW'(1)) : '0;
        if (empty) begin
          cmd_o.status = iss_pkg::ST_EMPTY;
        end else begin
          cmd_o.status = iss_pkg::ST_OK;
          cmd_o.del    = 1'b1;
        end
      end
      iss_pkg::OP_READ: begin
        pos_o = pos_w;
        if (pos_w < cnt_w) begin
          cmd_o.status = iss_pkg::ST_OK;
          cmd_o.rd_ok  = 1'b1;
        end else begin
          cmd_o.status  = iss_pkg::ST_BAD_POS;
          cmd_o.rd_fail = 1'b1;
        end
      end
      default: begin
        cmd_o.status = iss_pkg::ST_BAD_POS;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/iss_cells.sv -----
`default_nettype none

module iss_cells #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire iss_pkg::cmd_t                  cmd_i,
  input  wire logic [((($clog2(CAPACITY+1)) > iss_pkg::PosFldW) ?
                      $clog2(CAPACITY+1) : iss_pkg::PosFldW)-1:0] pos_i,
  input  wire logic [iss_pkg::DataW-1:0]      value_i,
  output logic      [$clog2(CAPACITY+1)-1:0]  cnt_o,
  output logic      [$clog2(CAPACITY+1)-1:0]  cnt_next_o,
  output logic      [iss_pkg::DataW-1:0]      rd_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PosW = (CntW > iss_pkg::PosFldW) ? CntW : iss_pkg::PosFldW;

  logic [iss_pkg::DataW-1:0] ent_q [CAPACITY];
  logic [CntW-1:0]           cnt_q;
  logic [CntW-1:0]           cnt_d;
  logic                      do_ins;
  logic                      do_del;

  assign do_ins = en_i && cmd_i.ins;
  assign do_del = en_i && cmd_i.del;

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_del) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // each cell picks its neighbor, the new value or itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PosW-1:0] MyIdx = PosW'(i);
    logic [iss_pkg::DataW-1:0] up_val;
    logic [iss_pkg::DataW-1:0] dn_val;

    if (i > 0) begin : g_up
      assign up_val = ent_q[i-1];
    end else begin : g_up0
      assign up_val = ent_q[i];
    end
    if (i < CAPACITY - 1) begin : g_dn
      assign dn_val = ent_q[i+1];
    end else begin : g_dn_last
      assign dn_val = ent_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins && (MyIdx == pos_i)) begin
        ent_q[i] <= value_i;
      end else if (do_ins && (MyIdx > pos_i)) begin
        ent_q[i] <= up_val;
      end else if (do_del && (MyIdx >= pos_i)) begin
        ent_q[i] <= dn_val;
      end
    end
  end

  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;
  assign rd_data_o  = ent_q[pos_i[IdxW-1:0]];

endmodule

`default_nettype wire

// ----- sim/indexed_sequence_store_test.sv -----
module indexed_sequence_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam logic [OpW-1:0] OpUnused = 3'd7;
  localparam int unsigned PosMax = (1 << PosFldW) - 1;
  localparam int unsigned Phases = 17;
  localparam int unsigned PhaseLen = 60;

  typedef struct {
    logic [OpW-1:0]          operation;
    logic [PosFldW-1:0]      position;
    logic signed [DataW-1:0] value;
    int unsigned             gap;    // idle cycles after this beat
    bit                      drain;  // hold this beat until every reply is back
  } request_t;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] read_value;
    logic [CntFldW-1:0]      entry_count;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  iss_req_if req_bus ();
  iss_rsp_if rsp_bus ();

  indexed_sequence_store #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  request_t requests_todo[$];
  reply_t   replies_due[$];

  // shadow of the list contents, in order from head to tail
  logic signed [DataW-1:0] list_words[Capacity];
  int unsigned list_len;
  int unsigned planned_len;

  request_t    in_flight;
  reply_t      next_reply;
  int unsigned send_idle;
  int unsigned send_gap_max = 3;
  int unsigned recv_stall;
  int unsigned recv_stall_max = 3;
  int unsigned beats_sent;
  int unsigned replies_seen;
  int unsigned errors;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned deepest;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic status_e insert_at(int unsigned at, logic signed [DataW-1:0] word);
    if (at > list_len) return ST_BAD_POS;
    if (list_len >= Capacity) return ST_FULL;
    for (int unsigned i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_len++;
    return ST_OK;
  endfunction

  function automatic status_e delete_at(int unsigned at);
    if (list_len == 0) return ST_EMPTY;
    if (at >= list_len) return ST_BAD_POS;
    for (int unsigned i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return ST_OK;
  endfunction

  task automatic apply_request(input request_t rq, output reply_t rp);
    rp.status = ST_BAD_POS;
    rp.read_value = '0;
    case (rq.operation)
      OP_INS_POS:  rp.status = insert_at(rq.position, rq.value);
      OP_INS_HEAD: rp.status = insert_at(0, rq.value);
      OP_INS_TAIL: rp.status = insert_at(list_len, rq.value);
      OP_DEL_POS:  rp.status = delete_at(rq.position);
      OP_DEL_HEAD: rp.status = delete_at(0);
      OP_DEL_TAIL: rp.status = delete_at((list_len == 0) ? 0 : list_len - 1);
      OP_READ: begin
        if (rq.position < list_len) begin
          rp.read_value = list_words[rq.position];
          rp.status = ST_OK;
        end else begin
          rp.read_value = '1;
        end
      end
      default: ;
    endcase
    rp.entry_count = list_len[CntFldW-1:0];
    if (rp.status == ST_FULL) full_hits++;
    if (rp.status == ST_EMPTY) empty_hits++;
    if (list_len > deepest) deepest = list_len;
  endtask

  // queue a request; planned_len follows the list length so positions can be aimed
  task automatic add_request(input logic [OpW-1:0] op, input int unsigned pos,
                             input logic signed [DataW-1:0] word, input bit drain);
    request_t rq;
    rq.operation = op;
    rq.position  = pos[PosFldW-1:0];
    rq.value     = word;
    rq.gap       = $urandom_range(0, send_gap_max);
    rq.drain     = drain;
    requests_todo.push_back(rq);
    case (op)
      OP_INS_POS: if (pos <= planned_len && planned_len < Capacity) planned_len++;
      OP_INS_HEAD, OP_INS_TAIL: if (planned_len < Capacity) planned_len++;
      OP_DEL_POS: if (pos < planned_len) planned_len--;
      OP_DEL_HEAD, OP_DEL_TAIL: if (planned_len != 0) planned_len--;
      default: ;
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      report("reply beat with no request outstanding");
      return;
    end
    want = replies_due.pop_front();
    if (rsp_bus.status !== want.status)
      report($sformatf("status %0d, expected %s", rsp_bus.status, want.status.name()));
    if (rsp_bus.read_value !== want.read_value)
      report($sformatf("read_value %0h, expected %0h", rsp_bus.read_value, want.read_value));
    if (rsp_bus.entry_count !== want.entry_count)
      report($sformatf("entry_count %0d, expected %0d", rsp_bus.entry_count,
                       want.entry_count));
  endtask

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        apply_request(in_flight, next_reply);
        replies_due.push_back(next_reply);
        beats_sent++;
        send_idle = in_flight.gap;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_idle != 0) begin
          send_idle--;
          req_bus.valid <= 1'b0;
        end else if (requests_todo.size() == 0 ||
                     (requests_todo[0].drain && replies_due.size() != 0)) begin
          req_bus.valid <= 1'b0;
        end else begin
          in_flight = requests_todo.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.operation <= in_flight.operation;
          req_bus.position  <= in_flight.position;
          req_bus.value     <= in_flight.value;
        end
      end
    end
  end

  // reply side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        check_reply();
        replies_seen++;
        recv_stall = $urandom_range(0, recv_stall_max);
        // switch between back-to-back and stalling stretches
        if (replies_seen % 50 == 0) recv_stall_max = $urandom_range(0, 1) ? 3 : 0;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned roll;
    int unsigned pos;
    logic [OpW-1:0] op;
    logic signed [DataW-1:0] word;

    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.operation = OP_READ;
    req_bus.position = '0;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;

    // empty list corner cases
    add_request(OP_READ, 0, 0, 1'b0);
    add_request(OP_DEL_HEAD, 0, 0, 1'b0);
    add_request(OP_DEL_TAIL, 5, 0, 1'b0);
    add_request(OP_DEL_POS, PosMax, 0, 1'b0);
    add_request(OP_INS_POS, 1, 1, 1'b0);
    // fill with extreme values from every insert flavor
    add_request(OP_INS_POS, 0, 32'sh8000_0000, 1'b0);
    add_request(OP_INS_HEAD, PosMax, 32'sh7fff_ffff, 1'b0);
    add_request(OP_INS_TAIL, 0, -32'sd1, 1'b0);
    add_request(OP_INS_POS, 1, 0, 1'b0);
    for (int unsigned i = 0; i <= 4; i++) add_request(OP_READ, i, 0, 1'b0);
    add_request(OP_DEL_POS, 4, 0, 1'b0);
    add_request(OP_DEL_POS, 1, 0, 1'b0);
    add_request(OpUnused, 0, 32'sh1234_5678, 1'b0);
    add_request(OP_INS_POS, 3, 32'sh5555_aaaa, 1'b0);
    add_request(OP_READ, 3, 0, 1'b0);
    add_request(OP_DEL_TAIL, 0, 0, 1'b0);
    add_request(OP_DEL_HEAD, 0, 0, 1'b0);
    add_request(OP_READ, 0, 0, 1'b0);

    // phases cycle grow / mixed / shrink so the list swings between full and empty
    for (int unsigned p = 0; p < Phases; p++) begin
      mode = p % 3;
      ins_pct = (mode == 0) ? 70 : (mode == 1) ? 40 : 15;
      del_pct = (mode == 0) ? 15 : (mode == 1) ? 40 : 65;
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      for (int unsigned k = 0; k < PhaseLen; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          op = OpUnused;
        end else if (roll < 2 + ins_pct) begin
          case ($urandom_range(0, 2))
            0: op = OP_INS_POS;
            1: op = OP_INS_HEAD;
            default: op = OP_INS_TAIL;
          endcase
        end else if (roll < 2 + ins_pct + del_pct) begin
          case ($urandom_range(0, 2))
            0: op = OP_DEL_POS;
            1: op = OP_DEL_HEAD;
            default: op = OP_DEL_TAIL;
          endcase
        end else begin
          op = OP_READ;
        end
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, PosMax);
        else if (op == OP_INS_POS) pos = $urandom_range(0, planned_len);
        else if (planned_len == 0) pos = 0;
        else pos = $urandom_range(0, planned_len - 1);
        case ($urandom_range(0, 15))
          0: word = 32'sh7fff_ffff;
          1: word = 32'sh8000_0000;
          2: word = -32'sd1;
          3: word = 0;
          default: word = $urandom;
        endcase
        add_request(op, pos, word, (k == 0) && (p % 4 == 1));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0 || req_bus.valid || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (replies_due.size() != 0)
      report($sformatf("%0d replies never arrived", replies_due.size()));

    $display("%0d requests, %0d replies checked, deepest list %0d of %0d", beats_sent,
             replies_seen, deepest, Capacity);
    $display("full rejections %0d, empty deletes %0d", full_hits, empty_hits);
    if (errors == 0) begin
      $display("indexed_sequence_store_test OK");
    end else begin
      $display("indexed_sequence_store_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the block");
    $display("indexed_sequence_store_test NOT OK");
    $finish;
  end

endmodule
